// ===== design/bptc_pkg.sv =====
// Package for the branch predecode / target calculation unit.
// Holds instruction class codes and match patterns; no dependencies.
package bptc_pkg;

    typedef enum logic [3:0] {
        K_PLAIN = 4'd0,
        K_SVC   = 4'd1,
        K_B     = 4'd2,
        K_BL    = 4'd3,
        K_RET   = 4'd4,
        K_BR    = 4'd5,
        K_BLR   = 4'd6,
        K_BCOND = 4'd7,
        K_CBZ   = 4'd8,
        K_TBZ   = 4'd9,
        K_ADR   = 4'd10,
        K_ADRP  = 4'd11
    } kind_t;

    localparam logic [31:0] SVC_WORD    = 32'hD400_1001;
    localparam logic [31:0] BIMM_MASK   = 32'hFC00_0000;
    localparam logic [31:0] B_PAT       = 32'h1400_0000;
    localparam logic [31:0] BL_PAT      = 32'h9400_0000;
    localparam logic [31:0] BREG_MASK   = 32'hFFFF_FC1F;
    localparam logic [31:0] RET_PAT     = 32'hD65F_0000;
    localparam logic [31:0] BR_PAT      = 32'hD61F_0000;
    localparam logic [31:0] BLR_PAT     = 32'hD63F_0000;
    localparam logic [31:0] BCOND_MASK  = 32'hFF00_0010;
    localparam logic [31:0] BCOND_PAT   = 32'h5400_0000;
    localparam logic [31:0] CMPB_MASK   = 32'h7E00_0000;
    localparam logic [31:0] CBZ_PAT     = 32'h3400_0000;
    localparam logic [31:0] TBZ_PAT     = 32'h3600_0000;
    localparam logic [31:0] ADR_MASK    = 32'h9F00_0000;
    localparam logic [31:0] ADR_PAT     = 32'h1000_0000;
    localparam logic [31:0] ADRP_PAT    = 32'h9000_0000;
    localparam logic [31:0] CB_KEEP     = 32'hFF00_001F;
    localparam logic [31:0] TB_KEEP     = 32'hFFF8_001F;
    localparam logic [63:0] PAGE_MASK   = 64'hFFFF_FFFF_FFFF_F000;
    localparam logic [31:0] INSN_BYTES  = 32'd4;

    // Decoded fields carried from the classify stage to the adder stages.
    typedef struct packed {
        kind_t       kind;
        logic        ends_block;
        logic        is_conditional;
        logic [4:0]  reg_index;
        logic [31:0] cond_bits;
    } dec_t;

endpackage

// ===== design/branch_predecode_target_calc_unit.sv =====
// Top level of the branch predecode / target calculation unit.
// Depends on bptc_pkg for class codes, match patterns and the decode struct.
//
//  channel  | handshake      | payload
//  ---------+----------------+------------------------------------------------
//  command  | start / busy   | pc, insn
//  result   | done (strobe)  | kind, ends_block, is_conditional, next_pc,
//           |                | target, reg_index, cond_bits
//
// One beat per cycle; each beat's result strobes done once stages 1, 2 and 3 have registered it.
// Stage 1 classifies and forms base and offset, stage 2 adds the low 32 bits,
// stage 3 adds the high 32 bits with the carry; that split sets the latency.
// busy is always low: the result side cannot stall, so nothing backs up.
// Reset clears the stage valid bits only.
module branch_predecode_target_calc_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [63:0]        pc,
    input  logic [31:0]        insn,
    output logic               done,
    output bptc_pkg::kind_t    kind,
    output logic               ends_block,
    output logic               is_conditional,
    output logic [63:0]        next_pc,
    output logic [63:0]        target,
    output logic [4:0]         reg_index,
    output logic [31:0]        cond_bits
);
    import bptc_pkg::*;

    logic        accept;
    dec_t        dec_next;
    logic [63:0] base_next;
    logic [63:0] off_next;
    logic [20:0] adr_imm;

    // stage 1
    logic        s1_valid_reg;
    dec_t        s1_dec_reg;
    logic [63:0] s1_base_reg;
    logic [63:0] s1_off_reg;
    logic [63:0] s1_pc_reg;

    // stage 2
    logic        s2_valid_reg;
    dec_t        s2_dec_reg;
    logic [31:0] s2_tgt_lo_reg;
    logic        s2_tgt_c_reg;
    logic [31:0] s2_base_hi_reg;
    logic [31:0] s2_off_hi_reg;
    logic [31:0] s2_npc_lo_reg;
    logic        s2_npc_c_reg;
    logic [31:0] s2_pc_hi_reg;
    logic [32:0] tgt_lo_sum;
    logic [32:0] npc_lo_sum;

    // stage 3 (output)
    logic        s3_valid_reg;
    dec_t        s3_dec_reg;
    logic [63:0] s3_target_reg;
    logic [63:0] s3_npc_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign adr_imm = {insn[23:5], insn[30:29]};

    always_comb
    begin
        dec_next  = '{kind: K_PLAIN, ends_block: 1'b0, is_conditional: 1'b0,
                      reg_index: 5'd0, cond_bits: 32'd0};
        base_next = 64'd0;
        off_next  = 64'd0;
        if (insn == SVC_WORD)
        begin
            dec_next.kind = K_SVC;
        end
        else if ((insn & BIMM_MASK) == B_PAT)
        begin
            dec_next.kind = K_B;
            base_next     = pc;
            off_next      = {{36{insn[25]}}, insn[25:0], 2'b00};
        end
        else if ((insn & BIMM_MASK) == BL_PAT)
        begin
            dec_next.kind = K_BL;
            base_next     = pc;
            off_next      = {{36{insn[25]}}, insn[25:0], 2'b00};
        end
        else if ((insn & BREG_MASK) == RET_PAT)
        begin
            dec_next.kind      = K_RET;
            dec_next.reg_index = insn[9:5];
        end
        else if ((insn & BREG_MASK) == BR_PAT)
        begin
            dec_next.kind      = K_BR;
            dec_next.reg_index = insn[9:5];
        end
        else if ((insn & BREG_MASK) == BLR_PAT)
        begin
            dec_next.kind      = K_BLR;
            dec_next.reg_index = insn[9:5];
        end
        else if ((insn & BCOND_MASK) == BCOND_PAT)
        begin
            dec_next.kind      = K_BCOND;
            dec_next.cond_bits = insn & CB_KEEP;
            base_next          = pc;
            off_next           = {{43{insn[23]}}, insn[23:5], 2'b00};
        end
        else if ((insn & CMPB_MASK) == CBZ_PAT)
        begin
            dec_next.kind      = K_CBZ;
            dec_next.cond_bits = insn & CB_KEEP;
            base_next          = pc;
            off_next           = {{43{insn[23]}}, insn[23:5], 2'b00};
        end
        else if ((insn & CMPB_MASK) == TBZ_PAT)
        begin
            dec_next.kind      = K_TBZ;
            dec_next.cond_bits = insn & TB_KEEP;
            base_next          = pc;
            off_next           = {{48{insn[18]}}, insn[18:5], 2'b00};
        end
        else if ((insn & ADR_MASK) == ADR_PAT)
        begin
            dec_next.kind      = K_ADR;
            dec_next.reg_index = insn[4:0];
            base_next          = pc;
            off_next           = {{43{adr_imm[20]}}, adr_imm};
        end
        else if ((insn & ADR_MASK) == ADRP_PAT)
        begin
            dec_next.kind      = K_ADRP;
            dec_next.reg_index = insn[4:0];
            base_next          = pc & PAGE_MASK;
            off_next           = {{31{adr_imm[20]}}, adr_imm, 12'd0};
        end
        dec_next.ends_block     = (dec_next.kind >= K_SVC) && (dec_next.kind <= K_TBZ);
        dec_next.is_conditional = (dec_next.kind >= K_BCOND) && (dec_next.kind <= K_TBZ);
    end

    assign tgt_lo_sum = {1'b0, s1_base_reg[31:0]} + {1'b0, s1_off_reg[31:0]};
    assign npc_lo_sum = {1'b0, s1_pc_reg[31:0]} + {1'b0, INSN_BYTES};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dec_reg  <= dec_next;
            s1_base_reg <= base_next;
            s1_off_reg  <= off_next;
            s1_pc_reg   <= pc;
        end
        if (s1_valid_reg)
        begin
            s2_dec_reg     <= s1_dec_reg;
            s2_tgt_lo_reg  <= tgt_lo_sum[31:0];
            s2_tgt_c_reg   <= tgt_lo_sum[32];
            s2_base_hi_reg <= s1_base_reg[63:32];
            s2_off_hi_reg  <= s1_off_reg[63:32];
            s2_npc_lo_reg  <= npc_lo_sum[31:0];
            s2_npc_c_reg   <= npc_lo_sum[32];
            s2_pc_hi_reg   <= s1_pc_reg[63:32];
        end
        if (s2_valid_reg)
        begin
            s3_dec_reg    <= s2_dec_reg;
            s3_target_reg <= {s2_base_hi_reg + s2_off_hi_reg + {31'd0, s2_tgt_c_reg},
                              s2_tgt_lo_reg};
            s3_npc_reg    <= {s2_pc_hi_reg + {31'd0, s2_npc_c_reg}, s2_npc_lo_reg};
        end
    end

    assign done           = s3_valid_reg;
    assign kind           = s3_dec_reg.kind;
    assign ends_block     = s3_dec_reg.ends_block;
    assign is_conditional = s3_dec_reg.is_conditional;
    assign next_pc        = s3_npc_reg;
    assign target         = s3_target_reg;
    assign reg_index      = s3_dec_reg.reg_index;
    assign cond_bits      = s3_dec_reg.cond_bits;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted beat did not strobe done three cycles later");

    a_cond_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_conditional) |-> ends_block)
        else $error("conditional branch not marked as ending the block");

    a_no_target: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kind == K_PLAIN || kind == K_SVC || kind == K_RET))
        |-> (target == 64'd0 && cond_bits == 32'd0))
        else $error("target or cond_bits nonzero for a class without them");

endmodule
